// ===== sv/taa_pkg.sv =====
// Shared types, constants and fixed-point helpers for the bounding box accumulator.
`default_nettype none
package taa_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_COEFS   = 12;
  localparam int COEF_IDX_W  = 4;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int SUM_W       = COORD_WIDTH + 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  localparam logic [1:0] OP_COEF   = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_LAST   = 2'd2;

  localparam logic signed [PROD_W-1:0] PROD_MAX =
    {{(PROD_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] PROD_MIN = ~PROD_MAX;
  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [COORD_WIDTH-1:0] COORD_ONE =
    COORD_WIDTH'(1) <<< FRAC_BITS;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic                  kind;
    logic [COEF_IDX_W-1:0] coef_index;
    coord_t                coef_value;
    coord_t                vx;
    coord_t                vy;
    coord_t                vz;
    logic                  last_vertex;
  } in_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
  } out_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [COEF_IDX_W-1:0] coef_index;
    coord_t                coef_value;
    coord_t                vx;
    coord_t                vy;
    coord_t                vz;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Floor to FRAC_BITS fraction bits, then clamp to the coordinate range.
  function automatic coord_t sat_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = p >>> FRAC_BITS;
    if (q > PROD_MAX) begin
      q = PROD_MAX;
    end else if (q < PROD_MIN) begin
      q = PROD_MIN;
    end
    return q[COORD_WIDTH-1:0];
  endfunction

  function automatic coord_t sat_sum(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = s;
    if (q > SUM_MAX) begin
      q = SUM_MAX;
    end else if (q < SUM_MIN) begin
      q = SUM_MIN;
    end
    return q[COORD_WIDTH-1:0];
  endfunction

  function automatic coord_t coef_reset(input int idx);
    coord_t v;
    v = '0;
    if (idx == 0 || idx == 5 || idx == 10) begin
      v = COORD_ONE;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/taa_front.sv =====
// Front end: accepts input transactions, classifies them and pushes work into the queue.
`default_nettype none
module taa_front (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  taa_pkg::in_t            in_data,
  input  taa_pkg::q_status_t      q_status,
  output logic                    push,
  output taa_pkg::q_entry_t       push_entry
);

  logic accept;
  logic idx_ok;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign idx_ok   = in_data.coef_index < taa_pkg::COEF_IDX_W'(taa_pkg::NUM_COEFS);

  always_comb begin
    push_entry.coef_index = in_data.coef_index;
    push_entry.coef_value = in_data.coef_value;
    push_entry.vx         = in_data.vx;
    push_entry.vy         = in_data.vy;
    push_entry.vz         = in_data.vz;
    unique case (in_data.kind)
      taa_pkg::KIND_COEF: begin
        // Loads to an index past the matrix do nothing, so they are dropped here.
        push_entry.op = taa_pkg::OP_COEF;
        push          = accept && idx_ok;
      end
      taa_pkg::KIND_VERTEX: begin
        push_entry.op = in_data.last_vertex ? taa_pkg::OP_LAST : taa_pkg::OP_VERTEX;
        push          = accept;
      end
      default: begin
        push_entry.op = taa_pkg::OP_VERTEX;
        push          = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/taa_queue.sv =====
// Short FIFO that decouples the front end from the transform back end.
`default_nettype none
module taa_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  taa_pkg::q_entry_t       push_entry,
  input  wire logic               pop,
  output taa_pkg::q_entry_t       head,
  output taa_pkg::q_status_t      status
);

  taa_pkg::q_entry_t           mem [taa_pkg::Q_DEPTH];
  logic [taa_pkg::Q_AW-1:0]    wr_ptr;
  logic [taa_pkg::Q_AW-1:0]    rd_ptr;
  logic [taa_pkg::Q_AW:0]      count;

  assign status.empty = (count == '0);
  assign status.full  = (count == (taa_pkg::Q_AW+1)'(taa_pkg::Q_DEPTH));
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + taa_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + taa_pkg::Q_AW'(1);
      end
      count <= count + (taa_pkg::Q_AW+1)'(push) - (taa_pkg::Q_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (taa_pkg::Q_AW+1)'(taa_pkg::Q_DEPTH))
    else $error("queue count exceeds depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== sv/taa_back.sv =====
// Back end: model matrix, transform pipeline, min/max accumulator and output register.
`default_nettype none
module taa_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  taa_pkg::q_entry_t       head,
  input  taa_pkg::q_status_t      q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output taa_pkg::out_t           out_data
);

  taa_pkg::coord_t coefs [taa_pkg::NUM_COEFS];

  logic advance;
  logic is_vertex;

  logic s1_valid, s1_last;
  logic s2_valid, s2_last;
  logic s3_valid, s3_last;

  logic signed [taa_pkg::PROD_W-1:0] s1_prod [3][3];
  taa_pkg::coord_t s1_trans [3];
  taa_pkg::coord_t s2_prod [3][3];
  taa_pkg::coord_t s2_trans [3];
  taa_pkg::coord_t s3_w [3];

  taa_pkg::coord_t lo [3];
  taa_pkg::coord_t hi [3];
  taa_pkg::coord_t lo_next [3];
  taa_pkg::coord_t hi_next [3];
  taa_pkg::coord_t ctr [3];
  logic has_point;

  logic signed [taa_pkg::COORD_WIDTH-1:0] vin [3];
  logic signed [taa_pkg::SUM_W-1:0] csum [3];

  assign advance   = !out_valid || !out_stall;
  assign pop       = advance && !q_status.empty;
  assign is_vertex = (head.op == taa_pkg::OP_VERTEX) || (head.op == taa_pkg::OP_LAST);

  assign vin[0] = head.vx;
  assign vin[1] = head.vy;
  assign vin[2] = head.vz;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo_next[r] = (!has_point || s3_w[r] < lo[r]) ? s3_w[r] : lo[r];
      hi_next[r] = (!has_point || s3_w[r] > hi[r]) ? s3_w[r] : hi[r];
      csum[r]    = (taa_pkg::SUM_W'(lo_next[r]) + taa_pkg::SUM_W'(hi_next[r])) >>> 1;
      ctr[r]     = csum[r][taa_pkg::COORD_WIDTH-1:0];
    end
  end

  // Control state and the matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < taa_pkg::NUM_COEFS; i++) begin
        coefs[i] <= taa_pkg::coef_reset(i);
      end
      s1_valid  <= 1'b0;
      s1_last   <= 1'b0;
      s2_valid  <= 1'b0;
      s2_last   <= 1'b0;
      s3_valid  <= 1'b0;
      s3_last   <= 1'b0;
      has_point <= 1'b0;
      out_valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        lo[r] <= '0;
        hi[r] <= '0;
      end
    end else begin
      if (pop && head.op == taa_pkg::OP_COEF) begin
        coefs[head.coef_index] <= head.coef_value;
      end
      if (advance) begin
        s1_valid  <= pop && is_vertex;
        s1_last   <= pop && (head.op == taa_pkg::OP_LAST);
        s2_valid  <= s1_valid;
        s2_last   <= s1_last;
        s3_valid  <= s2_valid;
        s3_last   <= s2_last;
        out_valid <= s3_valid && s3_last;
        if (s3_valid) begin
          has_point <= !s3_last;
          for (int r = 0; r < 3; r++) begin
            lo[r] <= s3_last ? '0 : lo_next[r];
            hi[r] <= s3_last ? '0 : hi_next[r];
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_prod[r][c] <= taa_pkg::PROD_W'(coefs[r*4+c]) * taa_pkg::PROD_W'(vin[c]);
          s2_prod[r][c] <= taa_pkg::sat_prod(s1_prod[r][c]);
        end
        s1_trans[r] <= coefs[r*4+3];
        s2_trans[r] <= s1_trans[r];
        s3_w[r] <= taa_pkg::sat_sum(taa_pkg::SUM_W'(s2_prod[r][0])
                                    + taa_pkg::SUM_W'(s2_prod[r][1])
                                    + taa_pkg::SUM_W'(s2_prod[r][2])
                                    + taa_pkg::SUM_W'(s2_trans[r]));
      end
      if (s3_valid && s3_last) begin
        out_data.min_x    <= lo_next[0];
        out_data.min_y    <= lo_next[1];
        out_data.min_z    <= lo_next[2];
        out_data.max_x    <= hi_next[0];
        out_data.max_y    <= hi_next[1];
        out_data.max_z    <= hi_next[2];
        out_data.center_x <= ctr[0];
        out_data.center_y <= ctr[1];
        out_data.center_z <= ctr[2];
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s3_valid && s3_last) |=> (!has_point && out_valid))
    else $error("box emission did not clear the accumulator");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(s3_valid) && $stable(has_point) && !$past(pop)))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule
`default_nettype wire

// ===== sv/transformed_aabb_accumulator_core.sv =====
// Top level of the world-space bounding box accumulator.
// A vertex marked last passes through the queue, the multiply, round-and-clamp and sum stages
// and the output register before its box shows on out_valid.
// Throughput: one transaction per cycle; the queue, the transform stages and the output
// register all advance together, limited only by the output stall.
// Reset: synchronous rst loads the identity matrix, clears the bounds and empties the queue.
`default_nettype none
module transformed_aabb_accumulator_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  taa_pkg::in_t       in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output taa_pkg::out_t      out_data
);

  // The front end decodes each transaction into a queue entry. Coefficient loads
  // with an index past the matrix are accepted and dropped, since they change nothing.
  // The input stalls only when the queue is full.
  logic               push;
  logic               pop;
  taa_pkg::q_entry_t  push_entry;
  taa_pkg::q_entry_t  head;
  taa_pkg::q_status_t q_status;

  taa_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // The queue lets the input keep flowing while the output is stalled, until its four entries are full.
  taa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // The back end applies coefficient loads in order with vertices, so a vertex always
  // sees the matrix as it was when that vertex was accepted. Vertices go through a
  // multiply stage, a round-and-clamp stage and a sum stage, then update the running
  // bounds. The whole back end freezes while a finished box waits on the output.
  taa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/transformed_aabb_accumulator_core_test.sv =====
// Self-checking testbench for the world-space bounding box accumulator core.
`timescale 1ns / 1ps
module transformed_aabb_accumulator_core_test;

  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 9;
  // Margin that covers loads and unmarked vertices that are still in flight.
  localparam int SETTLE_CYCLES    = 8;
  localparam int IDLE_LIMIT       = 2000;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int MAX_REPORTS      = 10;
  localparam int RANDOM_ITEMS     = 330;

  localparam taa_pkg::coord_t COORD_MAX = {1'b0, {(taa_pkg::COORD_WIDTH-1){1'b1}}};
  localparam taa_pkg::coord_t COORD_MIN = {1'b1, {(taa_pkg::COORD_WIDTH-1){1'b0}}};

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  taa_pkg::in_t    in_data;
  logic            out_valid;
  logic            out_stall;
  taa_pkg::out_t   out_data;

  transformed_aabb_accumulator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copy of the block state: model matrix, running bounds and the seed flag.
  taa_pkg::coord_t matrix_coefs [taa_pkg::NUM_COEFS];
  taa_pkg::coord_t box_lo [3];
  taa_pkg::coord_t box_hi [3];
  bit              box_seeded;

  // Boxes predicted at input acceptance, oldest first.
  taa_pkg::out_t expected_boxes [$];

  int unsigned fail_count    = 0;
  int unsigned report_count  = 0;
  int unsigned boxes_checked = 0;
  int unsigned idle_cycles   = 0;

  // Sender pacing: steady_sender forces back-to-back transactions, steady_left
  // is a randomly started run of transactions without gaps.
  bit          steady_sender;
  int unsigned steady_left;

  // Requested length of a long receiver hold; the stall process counts it down.
  int unsigned hold_left;

  string box_field_names [9] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z",
                                 "center_x", "center_y", "center_z"};

  // Clamp an exact value to the signed coordinate range.
  function automatic taa_pkg::coord_t clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) begin
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return taa_pkg::coord_t'(v);
  endfunction

  // Fixed-point product: exact, floored to FRAC_BITS fraction bits, then clamped.
  // Both operands are 32 bits, so the exact product always fits in a longint.
  function automatic taa_pkg::coord_t fixed_mul(input taa_pkg::coord_t a,
                                                input taa_pkg::coord_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return clamp_coord(prod >>> taa_pkg::FRAC_BITS);
  endfunction

  // Apply one accepted transaction to the shadow state, and queue the box it
  // closes when it is a vertex marked last.
  function automatic void advance_bbox_model(input taa_pkg::in_t t);
    taa_pkg::coord_t obj [3];
    taa_pkg::coord_t world [3];
    taa_pkg::coord_t mid [3];
    taa_pkg::out_t   box;
    longint acc;
    if (t.kind == taa_pkg::KIND_COEF) begin
      // Indexes past the end of the matrix are dropped, as is the last mark.
      if (t.coef_index < taa_pkg::NUM_COEFS) begin
        matrix_coefs[t.coef_index] = t.coef_value;
      end
      return;
    end
    obj = '{t.vx, t.vy, t.vz};
    for (int r = 0; r < 3; r++) begin
      // Translation column plus three rounded products, summed exactly.
      acc = longint'(matrix_coefs[r*4+3]);
      for (int c = 0; c < 3; c++) begin
        acc += longint'(fixed_mul(matrix_coefs[r*4+c], obj[c]));
      end
      world[r] = clamp_coord(acc);
      // The first vertex of a box seeds both bounds, whatever the cleared values.
      if (!box_seeded || world[r] < box_lo[r]) begin
        box_lo[r] = world[r];
      end
      if (!box_seeded || world[r] > box_hi[r]) begin
        box_hi[r] = world[r];
      end
    end
    box_seeded = 1'b1;
    if (!t.last_vertex) begin
      return;
    end
    // Centre is the floor of the exact midpoint, which always fits.
    for (int r = 0; r < 3; r++) begin
      mid[r] = taa_pkg::coord_t'((longint'(box_lo[r]) + longint'(box_hi[r])) >>> 1);
    end
    box.min_x    = box_lo[0];
    box.min_y    = box_lo[1];
    box.min_z    = box_lo[2];
    box.max_x    = box_hi[0];
    box.max_y    = box_hi[1];
    box.max_z    = box_hi[2];
    box.center_x = mid[0];
    box.center_y = mid[1];
    box.center_z = mid[2];
    expected_boxes.insert(expected_boxes.size(), box);
    // The matrix survives; the bounds go back to their cleared state.
    for (int r = 0; r < 3; r++) begin
      box_lo[r] = '0;
      box_hi[r] = '0;
    end
    box_seeded = 1'b0;
  endfunction

  // A coefficient load; the vertex fields are don't-care and get random bits.
  function automatic taa_pkg::in_t coef_load(input int unsigned idx,
                                             input taa_pkg::coord_t value,
                                             input bit last);
    taa_pkg::in_t t;
    t.kind        = taa_pkg::KIND_COEF;
    t.coef_index  = taa_pkg::COEF_IDX_W'(idx);
    t.coef_value  = value;
    t.vx          = taa_pkg::coord_t'($urandom);
    t.vy          = taa_pkg::coord_t'($urandom);
    t.vz          = taa_pkg::coord_t'($urandom);
    t.last_vertex = last;
    return t;
  endfunction

  // A vertex; the coefficient fields are don't-care and get random bits.
  function automatic taa_pkg::in_t vertex_item(input taa_pkg::coord_t x,
                                               input taa_pkg::coord_t y,
                                               input taa_pkg::coord_t z,
                                               input bit last);
    taa_pkg::in_t t;
    t.kind        = taa_pkg::KIND_VERTEX;
    t.coef_index  = taa_pkg::COEF_IDX_W'($urandom);
    t.coef_value  = taa_pkg::coord_t'($urandom);
    t.vx          = x;
    t.vy          = y;
    t.vz          = z;
    t.last_vertex = last;
    return t;
  endfunction

  // Mostly moderate values with a random magnitude, plus full-range words and
  // the extremes now and then.
  function automatic taa_pkg::coord_t rand_coord(input int unsigned min_shift,
                                                 input int unsigned max_shift);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      return taa_pkg::coord_t'($urandom);
    end
    if (pick == 3) begin
      return COORD_MAX;
    end
    if (pick == 4) begin
      return COORD_MIN;
    end
    if (pick == 5) begin
      return taa_pkg::coord_t'($urandom_range(0, 2)) - 1;
    end
    return taa_pkg::coord_t'($urandom) >>> $urandom_range(min_shift, max_shift);
  endfunction

  // Offer one transaction and hold it until accepted, then maybe leave a gap.
  // in_valid is only lowered when a gap follows, so it never toggles in a step.
  task automatic send_transaction(input taa_pkg::in_t t);
    int unsigned gap;
    int unsigned pick;
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    advance_bbox_model(t);
    gap = 0;
    if (!steady_sender) begin
      if (steady_left > 0) begin
        steady_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          steady_left = $urandom_range(20, 60);
        end else if (pick < 60) begin
          gap = 0;
        end else if (pick < 90) begin
          gap = $urandom_range(1, 3);
        end else begin
          gap = $urandom_range(8, 40);
        end
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every predicted box has come out, then let the pipeline
  // settle so that loads and unmarked vertices in flight are done too.
  task automatic wait_boxes_drained();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Identity matrix from reset: single-vertex box, full-range extremes with a
  // negative centre, and an all-negative box that must not keep the cleared zeros.
  task automatic test_identity_boxes();
    send_transaction(vertex_item('0, '0, '0, 1'b1));
    send_transaction(vertex_item(COORD_MAX, COORD_MIN, '0, 1'b0));
    send_transaction(vertex_item(COORD_MIN, COORD_MAX, -1, 1'b0));
    send_transaction(vertex_item(1, -1, COORD_MAX, 1'b1));
    send_transaction(vertex_item(-5 * taa_pkg::COORD_ONE, -3 * taa_pkg::COORD_ONE,
                                 -7 * taa_pkg::COORD_ONE, 1'b0));
    send_transaction(vertex_item(-2 * taa_pkg::COORD_ONE, -1 * taa_pkg::COORD_ONE,
                                 -4 * taa_pkg::COORD_ONE, 1'b1));
    wait_boxes_drained();
  endtask

  // A load carrying the last mark must not close a box, and indexes beyond the
  // matrix must leave it untouched.
  task automatic test_coefficient_loads();
    send_transaction(coef_load(3, 10 * taa_pkg::COORD_ONE, 1'b1));
    send_transaction(coef_load(12, COORD_MAX, 1'b1));
    send_transaction(coef_load(15, COORD_MIN, 1'b0));
    send_transaction(vertex_item(taa_pkg::COORD_ONE, 2 * taa_pkg::COORD_ONE,
                                 3 * taa_pkg::COORD_ONE, 1'b1));
    wait_boxes_drained();
  endtask

  // Rows of all-max and all-min coefficients drive products and sums into both
  // saturation limits; a raw -1 coefficient checks that products floor.
  task automatic test_saturating_transform();
    for (int i = 0; i < 4; i++) begin
      send_transaction(coef_load(i, COORD_MAX, 1'b0));
    end
    for (int i = 4; i < 8; i++) begin
      send_transaction(coef_load(i, COORD_MIN, 1'b1));
    end
    send_transaction(coef_load(8, -1, 1'b0));
    send_transaction(vertex_item(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
    send_transaction(vertex_item(1, -1, '0, 1'b0));
    send_transaction(vertex_item(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
    wait_boxes_drained();
  endtask

  // Objects built from one to three meshes, each mesh after a full, partial or no
  // matrix reload, with ignored loads mixed in as noise.
  task automatic test_random_objects(input int unsigned budget);
    int unsigned sent;
    int unsigned meshes;
    int unsigned verts;
    int unsigned pick;
    int unsigned n;
    sent = 0;
    while (sent < budget) begin
      meshes = $urandom_range(1, 3);
      for (int m = 0; m < meshes; m++) begin
        pick = $urandom_range(0, 99);
        if ((sent == 0 && m == 0) || pick < 15) begin
          for (int i = 0; i < taa_pkg::NUM_COEFS; i++) begin
            send_transaction(coef_load(i, rand_coord(10, 18), $urandom_range(0, 1)));
          end
          sent += taa_pkg::NUM_COEFS;
        end else if (pick < 60) begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            send_transaction(coef_load($urandom_range(0, taa_pkg::NUM_COEFS - 1),
                                       rand_coord(10, 18), $urandom_range(0, 1)));
          end
          sent += n;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_transaction(coef_load($urandom_range(taa_pkg::NUM_COEFS, 15),
                                     taa_pkg::coord_t'($urandom), $urandom_range(0, 1)));
        end
        verts = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 5);
        for (int v = 1; v <= verts; v++) begin
          send_transaction(vertex_item(rand_coord(6, 15), rand_coord(6, 15), rand_coord(6, 15),
                                       (m == meshes - 1) && (v == verts)));
        end
        sent += verts;
      end
      // Now and then the sender waits for every box before the next object.
      if ($urandom_range(0, 14) == 0) begin
        wait_boxes_drained();
      end
    end
    wait_boxes_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // short boxes back to back, so the block fills and stalls its input.
  task automatic test_output_hold();
    hold_left     = LONG_HOLD_CYCLES;
    steady_sender = 1'b1;
    for (int i = 0; i < 48; i++) begin
      send_transaction(vertex_item(rand_coord(6, 15), rand_coord(6, 15), rand_coord(6, 15),
                                   (i % 2) == 1));
    end
    steady_sender = 1'b0;
    wait_boxes_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Receiver stall pattern: mostly free-running, short and long stall bursts,
  // calm stretches with no stall at all, and the long hold when one is asked.
  initial begin : out_stall_pattern
    int unsigned burst_left;
    int unsigned calm_left;
    int unsigned pick;
    burst_left = 0;
    calm_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          burst_left = $urandom_range(15, 50);
        end else if (pick < 35) begin
          burst_left = $urandom_range(1, 3);
        end else if (pick < 45) begin
          calm_left = $urandom_range(20, 80);
        end
      end
    end
  end

  // Compare every accepted box with the oldest prediction, field by field.
  always @(posedge clk) begin : box_checker
    taa_pkg::out_t   want;
    taa_pkg::coord_t got_f [9];
    taa_pkg::coord_t want_f [9];
    if (!rst && out_valid && !out_stall) begin
      if (expected_boxes.size() == 0) begin
        fail_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("%0t: box result with no prediction pending: %p", $time, out_data);
        end
      end else begin
        want   = expected_boxes.pop_front();
        got_f  = '{out_data.min_x, out_data.min_y, out_data.min_z,
                   out_data.max_x, out_data.max_y, out_data.max_z,
                   out_data.center_x, out_data.center_y, out_data.center_z};
        want_f = '{want.min_x, want.min_y, want.min_z,
                   want.max_x, want.max_y, want.max_z,
                   want.center_x, want.center_y, want.center_z};
        for (int f = 0; f < 9; f++) begin
          if (got_f[f] !== want_f[f]) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
              report_count++;
              $display("%0t: box %0d field %s: expected %0d (0x%08h), got %0d (0x%08h)",
                       $time, boxes_checked, box_field_names[f],
                       want_f[f], want_f[f], got_f[f], got_f[f]);
            end
          end
        end
      end
      boxes_checked++;
    end
  end

  // Ends the run when neither side has completed a transaction for too long.
  always @(posedge clk) begin : progress_watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : run_tests
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    steady_sender = 1'b0;
    steady_left   = 0;
    hold_left     = 0;
    // Reset state: identity matrix, cleared bounds, no seed yet.
    foreach (matrix_coefs[i]) begin
      matrix_coefs[i] = '0;
    end
    matrix_coefs[0]  = taa_pkg::COORD_ONE;
    matrix_coefs[5]  = taa_pkg::COORD_ONE;
    matrix_coefs[10] = taa_pkg::COORD_ONE;
    for (int r = 0; r < 3; r++) begin
      box_lo[r] = '0;
      box_hi[r] = '0;
    end
    box_seeded = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_boxes();
    test_coefficient_loads();
    test_saturating_transform();
    test_random_objects(RANDOM_ITEMS);
    test_output_hold();
    wait_boxes_drained();

    if (fail_count == 0 && expected_boxes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/taa_pkg.sv
sv/taa_front.sv
sv/taa_queue.sv
sv/taa_back.sv
sv/transformed_aabb_accumulator_core.sv
tb/transformed_aabb_accumulator_core_test.sv
